### sv/qbvs_pkg.sv
package qbvs_pkg;

    localparam int MAX_QUADS_DEF = 8192;
    localparam int SLOTS_DEF     = 32;
    localparam int QC_W          = 14;
    localparam int SLOT_W        = 5;
    localparam int CW            = 34;
    localparam int ZW            = 18;
    localparam int Q_DEPTH       = 2;
    localparam logic [15:0] TIL_ONE = 16'd256;
    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [CW-1:0] ONE_Q30     = 34'sd1073741824;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] size_x;
        logic signed [31:0] size_y;
        logic [15:0]        angle;
        logic [31:0]        tint;
        logic [15:0]        texture_id;
        logic [15:0]        tiling;
    } t_in;

    typedef struct packed {
        logic signed [31:0] vert_x;
        logic signed [31:0] vert_y;
        logic signed [31:0] vert_z;
        logic [31:0]        color;
        logic               tex_u;
        logic               tex_v;
        logic [SLOT_W-1:0]  slot;
        logic [15:0]        tiling_out;
        logic               batch_start;
        logic               last;
    } t_out;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] size_x;
        logic signed [31:0] size_y;
        logic [31:0]        tint;
        logic [15:0]        tiling;
        logic [SLOT_W-1:0]  slot;
        logic               started;
        logic signed [31:0] sin_q30;
        logic signed [31:0] cos_q30;
    } t_task;

    typedef enum logic [1:0] {F_IDLE, F_CLASS, F_ROT, F_PUSH} t_fstate;
    typedef enum logic [1:0] {B_IDLE, B_MUL, B_SUM, B_OUT} t_bstate;

    // Arctangent of 2^-i in binary-angle units
    function automatic logic signed [ZW-1:0] atan_step(input logic [3:0] i);
        logic signed [ZW-1:0] r;
        case (i)
            4'd0:  r = 18'sd8192;
            4'd1:  r = 18'sd4836;
            4'd2:  r = 18'sd2555;
            4'd3:  r = 18'sd1297;
            4'd4:  r = 18'sd651;
            4'd5:  r = 18'sd326;
            4'd6:  r = 18'sd163;
            4'd7:  r = 18'sd81;
            4'd8:  r = 18'sd41;
            4'd9:  r = 18'sd20;
            4'd10: r = 18'sd10;
            4'd11: r = 18'sd5;
            4'd12: r = 18'sd3;
            4'd13: r = 18'sd1;
            4'd14: r = 18'sd1;
            default: r = 18'sd0;
        endcase
        return r;
    endfunction

endpackage

### sv/quad_batch_vertex_setup.sv
// Sprite quad vertex setup: one request in, four vertices out in corner order.
// The front unit runs a 16-step CORDIC per quad and can accept the next request while
// the back unit is still emitting the vertices of an earlier quad; the back unit
// stalls on i_ready.
// Reset (i_rst_n low, synchronous): quad count zero, one slot in use, queue and
// output empty; the texture slot table is not cleared.
module quad_batch_vertex_setup #(
    parameter int MAX_QUADS = qbvs_pkg::MAX_QUADS_DEF,
    parameter int SLOTS     = qbvs_pkg::SLOTS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  qbvs_pkg::t_in  i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output qbvs_pkg::t_out o_data
);
    import qbvs_pkg::*;

    logic  f_push, f_push_ready, q_valid, b_pop;
    t_task f_task, q_task;

    qbvs_front #(
        .MAX_QUADS(MAX_QUADS),
        .SLOTS    (SLOTS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .o_push      (f_push),
        .i_push_ready(f_push_ready),
        .o_task      (f_task)
    );

    qbvs_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (f_push),
        .o_push_ready(f_push_ready),
        .i_task      (f_task),
        .o_valid     (q_valid),
        .i_pop       (b_pop),
        .o_task      (q_task)
    );

    qbvs_back u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(q_valid),
        .o_pop  (b_pop),
        .i_task (q_task),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_data (o_data)
    );

endmodule

### sv/qbvs_front.sv
module qbvs_front #(
    parameter int MAX_QUADS = qbvs_pkg::MAX_QUADS_DEF,
    parameter int SLOTS     = qbvs_pkg::SLOTS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  qbvs_pkg::t_in   i_data,
    output logic            o_push,
    input  logic            i_push_ready,
    output qbvs_pkg::t_task o_task
);
    import qbvs_pkg::*;

    localparam int SU_W = $clog2(SLOTS + 1);
    localparam int IX_W = $clog2(SLOTS);

    t_fstate r_state, n_state;
    t_in     r_in;
    logic [QC_W-1:0] r_qc;
    logic [SU_W-1:0] r_su;
    logic [15:0]     r_tab [SLOTS];
    logic [IX_W-1:0] r_slot;
    logic            r_started;
    logic [15:0]     r_til;
    logic signed [CW-1:0] r_x, r_y;
    logic signed [ZW-1:0] r_z;
    logic            r_flip;
    logic [3:0]      r_it;

    logic            c_started, c_found, c_wr;
    logic [SU_W-1:0] c_su, c_new_su;
    logic [IX_W-1:0] c_hit, c_slot;
    logic [15:0]     c_til;
    logic signed [ZW-1:0] c_z0, c_zf;
    logic            c_flip;
    logic signed [CW-1:0] c_xs, c_ys, c_fx, c_fy, c_cx, c_cy;

    // Classify: batch limit, slot lookup, slot allocation
    always_comb begin
        c_started = (r_qc >= QC_W'(MAX_QUADS));
        c_su      = c_started ? SU_W'(1) : r_su;
        c_found   = 1'b0;
        c_hit     = '0;
        for (int i = 1; i < SLOTS; i++) begin
            if (!c_found && (SU_W'(i) < c_su) && (r_tab[i] == r_in.texture_id)) begin
                c_found = 1'b1;
                c_hit   = IX_W'(i);
            end
        end
        c_new_su = c_su;
        c_slot   = '0;
        c_wr     = 1'b0;
        c_til    = r_in.tiling;
        if (r_in.texture_id != 16'd0) begin
            if (c_found) begin
                c_slot = c_hit;
            end else begin
                if (c_su >= SU_W'(SLOTS)) begin
                    c_started = 1'b1;
                    c_su      = SU_W'(1);
                end
                c_slot   = IX_W'(c_su);
                c_wr     = 1'b1;
                c_new_su = c_su + SU_W'(1);
            end
        end else begin
            c_til = TIL_ONE;
        end
    end

    // Fold the angle into a quarter turn either side of zero
    always_comb begin
        c_z0   = {{(ZW-16){r_in.angle[15]}}, r_in.angle};
        c_zf   = c_z0;
        c_flip = 1'b0;
        if (c_z0 > 18'sd16384) begin
            c_zf   = c_z0 - 18'sd32768;
            c_flip = 1'b1;
        end else if (c_z0 < -18'sd16384) begin
            c_zf   = c_z0 + 18'sd32768;
            c_flip = 1'b1;
        end
    end

    // Rotation step and final clamp
    always_comb begin
        c_xs = r_x >>> r_it;
        c_ys = r_y >>> r_it;
        c_fx = r_flip ? -r_x : r_x;
        c_fy = r_flip ? -r_y : r_y;
        c_cx = c_fx;
        c_cy = c_fy;
        if (c_fx > ONE_Q30) c_cx = ONE_Q30;
        else if (c_fx < -ONE_Q30) c_cx = -ONE_Q30;
        if (c_fy > ONE_Q30) c_cy = ONE_Q30;
        else if (c_fy < -ONE_Q30) c_cy = -ONE_Q30;
    end

    always_comb begin
        n_state = r_state;
        o_ready = 1'b0;
        o_push  = 1'b0;
        case (r_state)
            F_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) n_state = F_CLASS;
            end
            F_CLASS: n_state = F_ROT;
            F_ROT: begin
                if (r_it == 4'd15) n_state = F_PUSH;
            end
            F_PUSH: begin
                o_push = 1'b1;
                if (i_push_ready) n_state = F_IDLE;
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_comb begin
        o_task.pos_x   = r_in.pos_x;
        o_task.pos_y   = r_in.pos_y;
        o_task.pos_z   = r_in.pos_z;
        o_task.size_x  = r_in.size_x;
        o_task.size_y  = r_in.size_y;
        o_task.tint    = r_in.tint;
        o_task.tiling  = r_til;
        o_task.slot    = SLOT_W'(r_slot);
        o_task.started = r_started;
        o_task.sin_q30 = 32'(c_cy);
        o_task.cos_q30 = 32'(c_cx);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_qc    <= '0;
            r_su    <= SU_W'(1);
        end else begin
            r_state <= n_state;
            if (r_state == F_CLASS) begin
                r_qc <= (c_started ? QC_W'(0) : r_qc) + QC_W'(1);
                r_su <= c_new_su;
            end
        end
    end

    // Hold the transaction, update the slot table, run the rotation
    always_ff @(posedge i_clk) begin
        case (r_state)
            F_IDLE: begin
                if (i_valid) r_in <= i_data;
            end
            F_CLASS: begin
                if (c_wr) r_tab[c_slot] <= r_in.texture_id;
                r_slot    <= c_slot;
                r_started <= c_started;
                r_til     <= c_til;
                r_x       <= CORDIC_GAIN;
                r_y       <= '0;
                r_z       <= c_zf;
                r_flip    <= c_flip;
                r_it      <= 4'd0;
            end
            F_ROT: begin
                if (r_z >= 0) begin
                    r_x <= r_x - c_ys;
                    r_y <= r_y + c_xs;
                    r_z <= r_z - atan_step(r_it);
                end else begin
                    r_x <= r_x + c_ys;
                    r_y <= r_y - c_xs;
                    r_z <= r_z + atan_step(r_it);
                end
                r_it <= r_it + 4'd1;
            end
            default: begin
            end
        endcase
    end

endmodule

### sv/qbvs_queue.sv
module qbvs_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    output logic            o_push_ready,
    input  qbvs_pkg::t_task i_task,
    output logic            o_valid,
    input  logic            i_pop,
    output qbvs_pkg::t_task o_task
);
    import qbvs_pkg::*;

    t_task r_mem [Q_DEPTH];
    logic  r_wp, r_rp;
    logic [1:0] r_cnt;
    logic  c_wr, c_rd;

    assign o_push_ready = (r_cnt < 2'(Q_DEPTH));
    assign o_valid      = (r_cnt != 2'd0);
    assign o_task       = r_mem[r_rp];
    assign c_wr         = i_push && o_push_ready;
    assign c_rd         = i_pop && o_valid;

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (c_wr) r_wp <= ~r_wp;
            if (c_rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(c_wr) - 2'(c_rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_wr) r_mem[r_wp] <= i_task;
    end

`ifndef NO_ASSERTIONS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'(Q_DEPTH))
        else $error("queue count beyond depth");
    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wp == r_rp) |-> (r_cnt == 2'd0 || r_cnt == 2'(Q_DEPTH)))
        else $error("queue pointers disagree with count");
    a_push_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0 && i_push) |=> o_valid)
        else $error("pushed transaction not visible");
`endif

endmodule

### sv/qbvs_back.sv
module qbvs_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_pop,
    input  qbvs_pkg::t_task i_task,
    output logic            o_valid,
    input  logic            i_ready,
    output qbvs_pkg::t_out  o_data
);
    import qbvs_pkg::*;

    localparam logic signed [63:0] ROUND = 64'sd1073741824;

    t_bstate r_state, n_state;
    t_task   r_task;
    logic [1:0] r_cnt, r_k;
    logic signed [63:0] r_p [4];
    logic signed [63:0] r_sx, r_sy;
    logic    r_ovalid, n_ovalid;
    t_out    r_out, c_out;
    logic    c_load, c_upos, c_vpos;
    logic signed [31:0] m_a, m_b;
    logic signed [63:0] m_p;
    logic signed [33:0] c_vx, c_vy;
    logic signed [31:0] c_sx, c_sy;

    // Shared multiplier: cos*sx, sin*sy, sin*sx, cos*sy
    always_comb begin
        m_a = (r_cnt == 2'd0 || r_cnt == 2'd3) ? r_task.cos_q30 : r_task.sin_q30;
        m_b = r_cnt[0] ? r_task.size_y : r_task.size_x;
        m_p = m_a * m_b;
    end

    assign c_upos = (r_k == 2'd1) || (r_k == 2'd2);
    assign c_vpos = r_k[1];

    // Round to Q16.16, add the centre, saturate
    always_comb begin
        c_vx = {r_sx[63], r_sx[63:31]} + 34'(r_task.pos_x);
        c_vy = {r_sy[63], r_sy[63:31]} + 34'(r_task.pos_y);
        if (c_vx > 34'sd2147483647) c_sx = 32'sh7FFFFFFF;
        else if (c_vx < -34'sd2147483648) c_sx = 32'sh80000000;
        else c_sx = 32'(c_vx);
        if (c_vy > 34'sd2147483647) c_sy = 32'sh7FFFFFFF;
        else if (c_vy < -34'sd2147483648) c_sy = 32'sh80000000;
        else c_sy = 32'(c_vy);
        c_out.vert_x      = c_sx;
        c_out.vert_y      = c_sy;
        c_out.vert_z      = r_task.pos_z;
        c_out.color       = r_task.tint;
        c_out.tex_u       = c_upos;
        c_out.tex_v       = c_vpos;
        c_out.slot        = r_task.slot;
        c_out.tiling_out  = r_task.tiling;
        c_out.batch_start = r_task.started && (r_k == 2'd0);
        c_out.last        = (r_k == 2'd3);
    end

    always_comb begin
        n_state  = r_state;
        o_pop    = 1'b0;
        c_load   = 1'b0;
        n_ovalid = r_ovalid && !i_ready;
        case (r_state)
            B_IDLE: begin
                if (i_valid) begin
                    o_pop   = 1'b1;
                    n_state = B_MUL;
                end
            end
            B_MUL: begin
                if (r_cnt == 2'd3) n_state = B_SUM;
            end
            B_SUM: n_state = B_OUT;
            B_OUT: begin
                if (!r_ovalid || i_ready) begin
                    c_load   = 1'b1;
                    n_ovalid = 1'b1;
                    n_state  = (r_k == 2'd3) ? B_IDLE : B_SUM;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    // Multiply, sum per corner, load the output register
    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                if (i_valid) r_task <= i_task;
                r_cnt <= 2'd0;
                r_k   <= 2'd0;
            end
            B_MUL: begin
                r_p[r_cnt] <= m_p;
                r_cnt      <= r_cnt + 2'd1;
            end
            B_SUM: begin
                r_sx <= (c_upos ? r_p[0] : -r_p[0]) + (c_vpos ? -r_p[1] : r_p[1]) + ROUND;
                r_sy <= (c_upos ? r_p[2] : -r_p[2]) + (c_vpos ? r_p[3] : -r_p[3]) + ROUND;
            end
            B_OUT: begin
                if (c_load) r_k <= r_k + 2'd1;
            end
            default: begin
            end
        endcase
        if (c_load) r_out <= c_out;
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_out;

endmodule
